// File: hdl/cdoa_pkg.sv
package cdoa_pkg;

    localparam int AMOUNT_WIDTH_DEF = 16;
    localparam int MAX_YEAR_DEF     = 5000;

    localparam int YEAR_W     = 13;
    localparam int NEW_YEAR_W = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int DIVISOR_W  = 9;
    localparam int WALK_W     = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;

    localparam logic [DIVISOR_W-1:0] DIV_MONTHS = 9'd12;
    localparam logic [DIVISOR_W-1:0] DIV_YEAR   = 9'd365;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DAYS,
        OP_MONTHS,
        OP_YEARS
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DS_LOW,
        DS_HIGH,
        DS_QUOT,
        DS_REM
    } div_step_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    function automatic logic [DAY_W-1:0] days_of(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m) inside
            MONTH_FEB:
            begin
                d = DAYS_FEB;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:
            begin
                d = DAYS_SHORT;
            end
            default:
            begin
                d = DAYS_LONG;
            end
        endcase
        return d;
    endfunction

endpackage

// File: hdl/cdoa_fifo.sv
module cdoa_fifo
    import cdoa_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/cdoa_front.sv
module cdoa_front
    import cdoa_pkg::*;
#(
    parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF,
    parameter int MAX_YEAR     = MAX_YEAR_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     req_type,
    input  logic signed [NEW_YEAR_W-1:0]   new_year,
    input  logic [MONTH_W-1:0]             new_month,
    input  logic [DAY_W-1:0]               new_day,
    input  logic signed [AMOUNT_WIDTH-1:0] amount,
    output logic                           cmd_valid,
    output op_t                            cmd_op,
    output date_t                          cmd_date,
    output logic signed [AMOUNT_WIDTH-1:0] cmd_amount,
    input  logic                           cmd_take
);

    localparam int CMD_W = $bits(op_t) + $bits(date_t) + AMOUNT_WIDTH;

    date_t             load_date;
    logic [DAY_W-1:0]  load_days;
    logic [CMD_W-1:0]  push_data;
    logic [CMD_W-1:0]  pop_data;
    logic              q_empty;

    // load clipping: year, then month, then day against the clipped month
    always_comb
    begin
        if (new_year[NEW_YEAR_W-1])
        begin
            load_date.year = '0;
        end
        else if (new_year[YEAR_W-1:0] > YEAR_W'(MAX_YEAR))
        begin
            load_date.year = YEAR_W'(MAX_YEAR);
        end
        else
        begin
            load_date.year = new_year[YEAR_W-1:0];
        end

        if (new_month < MONTH_JAN)
        begin
            load_date.month = MONTH_JAN;
        end
        else if (new_month > MONTH_DEC)
        begin
            load_date.month = MONTH_DEC;
        end
        else
        begin
            load_date.month = new_month;
        end

        load_days = days_of(load_date.month);
        if (new_day == '0)
        begin
            load_date.day = DAY_W'(1);
        end
        else if (new_day > load_days)
        begin
            load_date.day = load_days;
        end
        else
        begin
            load_date.day = new_day;
        end
    end

    assign push_data = {req_type, load_date, amount};

    cdoa_fifo #(
        .W     (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (cmd_take),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign cmd_valid  = !q_empty;
    assign cmd_op     = op_t'(pop_data[CMD_W-1 -: $bits(op_t)]);
    assign cmd_date   = pop_data[AMOUNT_WIDTH +: $bits(date_t)];
    assign cmd_amount = pop_data[AMOUNT_WIDTH-1:0];

endmodule

// File: hdl/cdoa_div.sv
module cdoa_div
    import cdoa_pkg::*;
#(
    parameter int DW = AMOUNT_WIDTH_DEF + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 busy,
    output logic [DW-1:0]        quotient,
    output logic [DIVISOR_W-1:0] remainder
);

    localparam int MW     = DW + 1;
    localparam int PW     = 2 * DW + 1;
    localparam int HW     = (DW + 1) / 2;
    localparam int S_MON  = DW + 4;
    localparam int S_YEAR = DW + 9;
    localparam logic [MW-1:0] M_MON  =
        MW'(((longint'(1) << S_MON) + longint'(DIV_MONTHS) - 1) / longint'(DIV_MONTHS));
    localparam logic [MW-1:0] M_YEAR =
        MW'(((longint'(1) << S_YEAR) + longint'(DIV_YEAR) - 1) / longint'(DIV_YEAR));

    logic [DW-1:0]           x_reg, x_next;
    logic                    year_reg, year_next;
    div_step_t               step_reg, step_next;
    logic                    busy_reg, busy_next;
    logic [PW-1:0]           acc_reg, acc_next;
    logic [DW-1:0]           quo_reg, quo_next;
    logic [DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [MW-1:0]           recip;
    logic [DIVISOR_W-1:0]    dsr;
    logic [HW-1:0]           mul_a;
    logic [HW+MW-1:0]        mul_p;
    logic [DW+DIVISOR_W-1:0] qd;
    logic [DW-1:0]           diff;

    // reciprocal multiply in two half passes, then quotient, then remainder
    assign recip = year_reg ? M_YEAR : M_MON;
    assign dsr   = year_reg ? DIV_YEAR : DIV_MONTHS;
    assign mul_a = (step_reg == DS_LOW) ? x_reg[HW-1:0] : HW'(x_reg[DW-1:HW]);
    assign mul_p = mul_a * recip;
    assign qd    = {{DIVISOR_W{1'b0}}, quo_reg} * {{DW{1'b0}}, dsr};
    assign diff  = x_reg - qd[DW-1:0];

    always_comb
    begin
        x_next    = x_reg;
        year_next = year_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            x_next    = dividend;
            year_next = (divisor == DIV_YEAR);
            step_next = DS_LOW;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                DS_LOW:
                begin
                    acc_next  = PW'(mul_p);
                    step_next = DS_HIGH;
                end
                DS_HIGH:
                begin
                    acc_next  = acc_reg + (PW'(mul_p) << HW);
                    step_next = DS_QUOT;
                end
                DS_QUOT:
                begin
                    quo_next  = year_reg ? DW'(acc_reg[PW-1:S_YEAR]) : DW'(acc_reg[PW-1:S_MON]);
                    step_next = DS_REM;
                end
                default:
                begin
                    rem_next  = diff[DIVISOR_W-1:0];
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= DS_LOW;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        year_reg <= year_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/cdoa_back.sv
module cdoa_back
    import cdoa_pkg::*;
#(
    parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF,
    parameter int MAX_YEAR     = MAX_YEAR_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  op_t                            cmd_op,
    input  date_t                          cmd_date,
    input  logic signed [AMOUNT_WIDTH-1:0] cmd_amount,
    output logic                           cmd_take,
    output logic                           res_push,
    output date_t                          res_date,
    input  logic                           res_full
);

    localparam int DW = (AMOUNT_WIDTH + 1 > WALK_W) ? AMOUNT_WIDTH + 1 : WALK_W;
    localparam int SW = ((DW > YEAR_W) ? DW : YEAR_W) + 2;
    localparam logic signed [SW-1:0] MAX_YEAR_S   = SW'(MAX_YEAR);
    localparam logic signed [DW-1:0] YEAR_DAYS_S  = DW'(DIV_YEAR);
    localparam logic signed [DW-1:0] NYEAR_DAYS_S = -YEAR_DAYS_S;

    state_t                 state_reg, state_next;
    date_t                  date_reg, date_next;
    op_t                    op_reg, op_next;
    logic                   neg_reg, neg_next;
    logic signed [WALK_W-1:0] walk_reg, walk_next;

    logic                   div_start;
    logic [DW-1:0]          div_dividend;
    logic [DIVISOR_W-1:0]   div_divisor;
    logic                   div_busy;
    logic [DW-1:0]          div_quo;
    logic [DIVISOR_W-1:0]   div_rem;

    logic signed [DW-1:0]   amt_w;
    logic signed [DW-1:0]   month_w;
    logic signed [DW-1:0]   day_w;
    logic signed [DW-1:0]   t_w;
    logic signed [DW-1:0]   r_w;
    logic [DW:0]            quo_x;
    logic [DAY_W-1:0]       cur_days;
    logic [MONTH_W-1:0]     prev_month;

    function automatic logic [YEAR_W-1:0] sat_year(input logic [YEAR_W-1:0] y,
                                                   input logic [DW:0] q);
        logic signed [SW-1:0] s;
        s = $signed({{(SW-YEAR_W){1'b0}}, y}) + $signed({{(SW-DW-1){q[DW]}}, q});
        if (s[SW-1])
        begin
            return '0;
        end
        else if (s > MAX_YEAR_S)
        begin
            return YEAR_W'(MAX_YEAR);
        end
        return s[YEAR_W-1:0];
    endfunction

    assign amt_w      = {{(DW-AMOUNT_WIDTH){cmd_amount[AMOUNT_WIDTH-1]}}, cmd_amount};
    assign month_w    = {{(DW-MONTH_W){1'b0}}, date_reg.month};
    assign day_w      = {{(DW-DAY_W){1'b0}}, date_reg.day};
    assign t_w        = month_w + amt_w - DW'(1);
    assign r_w        = day_w + amt_w;
    assign quo_x      = {1'b0, div_quo};
    assign cur_days   = days_of(date_reg.month);
    assign prev_month = (date_reg.month == MONTH_JAN) ? MONTH_DEC : date_reg.month - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        date_next    = date_reg;
        op_next      = op_reg;
        neg_next     = neg_reg;
        walk_next    = walk_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = DIV_MONTHS;
        cmd_take     = 1'b0;
        res_push     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    op_next  = cmd_op;
                    case (cmd_op)
                        OP_LOAD:
                        begin
                            date_next  = cmd_date;
                            state_next = ST_EMIT;
                        end
                        OP_YEARS:
                        begin
                            date_next.year = sat_year(date_reg.year, {amt_w[DW-1], amt_w});
                            state_next     = ST_EMIT;
                        end
                        OP_MONTHS:
                        begin
                            neg_next     = t_w[DW-1];
                            div_start    = 1'b1;
                            div_dividend = t_w[DW-1] ? -t_w : t_w;
                            div_divisor  = DIV_MONTHS;
                            state_next   = ST_DIV;
                        end
                        default:
                        begin
                            if (r_w > YEAR_DAYS_S)
                            begin
                                neg_next     = 1'b0;
                                div_start    = 1'b1;
                                div_dividend = r_w - DW'(1);
                                div_divisor  = DIV_YEAR;
                                state_next   = ST_DIV;
                            end
                            else if (r_w <= NYEAR_DAYS_S)
                            begin
                                neg_next     = 1'b1;
                                div_start    = 1'b1;
                                div_dividend = -r_w;
                                div_divisor  = DIV_YEAR;
                                state_next   = ST_DIV;
                            end
                            else
                            begin
                                walk_next  = r_w[WALK_W-1:0];
                                state_next = ST_WALK;
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    if (op_reg == OP_MONTHS)
                    begin
                        if (!neg_reg)
                        begin
                            date_next.month = div_rem[MONTH_W-1:0] + 1'b1;
                            date_next.year  = sat_year(date_reg.year, quo_x);
                        end
                        else if (div_rem == '0)
                        begin
                            date_next.month = MONTH_JAN;
                            date_next.year  = sat_year(date_reg.year, -quo_x);
                        end
                        else
                        begin
                            date_next.month = MONTH_DEC + 1'b1 - div_rem[MONTH_W-1:0];
                            date_next.year  = sat_year(date_reg.year, ~quo_x);
                        end
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        if (!neg_reg)
                        begin
                            walk_next      = $signed({1'b0, div_rem}) + WALK_W'(1);
                            date_next.year = sat_year(date_reg.year, quo_x);
                        end
                        else
                        begin
                            walk_next      = -$signed({1'b0, div_rem});
                            date_next.year = sat_year(date_reg.year, -quo_x);
                        end
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // one month per cycle until the day fits
                if (walk_reg[WALK_W-1] || walk_reg == '0)
                begin
                    date_next.month = prev_month;
                    if (date_reg.month == MONTH_JAN && date_reg.year != '0)
                    begin
                        date_next.year = date_reg.year - 1'b1;
                    end
                    walk_next = walk_reg + $signed({{(WALK_W-DAY_W){1'b0}}, days_of(prev_month)});
                end
                else if (walk_reg > $signed({{(WALK_W-DAY_W){1'b0}}, cur_days}))
                begin
                    walk_next = walk_reg - $signed({{(WALK_W-DAY_W){1'b0}}, cur_days});
                    if (date_reg.month == MONTH_DEC)
                    begin
                        date_next.month = MONTH_JAN;
                        if (date_reg.year != YEAR_W'(MAX_YEAR))
                        begin
                            date_next.year = date_reg.year + 1'b1;
                        end
                    end
                    else
                    begin
                        date_next.month = date_reg.month + 1'b1;
                    end
                end
                else
                begin
                    date_next.day = walk_reg[DAY_W-1:0];
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                res_push = 1'b1;
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            date_reg.year  <= '0;
            date_reg.month <= MONTH_JAN;
            date_reg.day   <= DAY_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            date_reg  <= date_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        walk_reg <= walk_next;
    end

    cdoa_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign res_date = date_reg;

endmodule

// File: hdl/calendar_date_offset_adder.sv
// channel   direction  handshake        payload
// request   in         push / full      req_type, new_year, new_month, new_day, amount
// result    out        empty / pop      cur_year, cur_month, cur_day
//
// a load or a year add holds the back end only to take, then write the result
// a month add passes the reciprocal divider, then writes the result
// a day add within a year walks one month per cycle (up to 13 steps);
// larger offsets first pass the divider, then walk
// reset sets the date to year 0, January 1 and empties both queues
// requests queue while the back end works; a full result queue stalls it
module calendar_date_offset_adder
    import cdoa_pkg::*;
#(
    parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF,
    parameter int MAX_YEAR     = MAX_YEAR_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     req_type,
    input  logic signed [NEW_YEAR_W-1:0]   new_year,
    input  logic [MONTH_W-1:0]             new_month,
    input  logic [DAY_W-1:0]               new_day,
    input  logic signed [AMOUNT_WIDTH-1:0] amount,
    output logic                           empty,
    input  logic                           pop,
    output logic [YEAR_W-1:0]              cur_year,
    output logic [MONTH_W-1:0]             cur_month,
    output logic [DAY_W-1:0]               cur_day
);

    logic                           cmd_valid;
    op_t                            cmd_op;
    date_t                          cmd_date;
    logic signed [AMOUNT_WIDTH-1:0] cmd_amount;
    logic                           cmd_take;
    logic                           res_push;
    date_t                          res_date;
    logic                           res_full;
    date_t                          out_date;

    cdoa_front #(
        .AMOUNT_WIDTH (AMOUNT_WIDTH),
        .MAX_YEAR     (MAX_YEAR)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .new_year   (new_year),
        .new_month  (new_month),
        .new_day    (new_day),
        .amount     (amount),
        .cmd_valid  (cmd_valid),
        .cmd_op     (cmd_op),
        .cmd_date   (cmd_date),
        .cmd_amount (cmd_amount),
        .cmd_take   (cmd_take)
    );

    cdoa_back #(
        .AMOUNT_WIDTH (AMOUNT_WIDTH),
        .MAX_YEAR     (MAX_YEAR)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_op     (cmd_op),
        .cmd_date   (cmd_date),
        .cmd_amount (cmd_amount),
        .cmd_take   (cmd_take),
        .res_push   (res_push),
        .res_date   (res_date),
        .res_full   (res_full)
    );

    cdoa_fifo #(
        .W     ($bits(date_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_date),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (out_date),
        .empty     (empty)
    );

    assign cur_year  = out_date.year;
    assign cur_month = out_date.month;
    assign cur_day   = out_date.day;

endmodule
